>>> hdl/client_lease_cooldown_table_core_macros.svh
// Assertion macros for the client lease and cooldown table.
`ifndef CLIENT_LEASE_COOLDOWN_TABLE_CORE_MACROS_SVH
`define CLIENT_LEASE_COOLDOWN_TABLE_CORE_MACROS_SVH
`ifndef SYNTH
`define CLCT_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define CLCT_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define CLCT_ASSERT_IMP(label, clk, rst, a, c)
`define CLCT_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> hdl/clct_pkg.sv
// Shared types and constants for the client lease and cooldown table.
`timescale 1ns / 1ps
package clct_pkg;
   localparam int LEASE_SLOTS_DEF = 8;
   localparam int COOL_SLOTS_DEF  = 8;
   localparam logic [1:0] KIND_SEEN   = 2'd0;
   localparam logic [1:0] KIND_SCAN   = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] ST_UNKNOWN   = 2'd0;
   localparam logic [1:0] ST_ACTIVE    = 2'd1;
   localparam logic [1:0] ST_UNLIMITED = 2'd2;
   localparam logic [1:0] ST_BLOCKED   = 2'd3;
   localparam logic [1:0] REG_SESSION  = 2'd0;
   localparam logic [1:0] REG_COOLDOWN = 2'd1;
   localparam logic [1:0] REG_STALE    = 2'd2;
   localparam logic [31:0] SESSION_RST  = 32'd3600000;
   localparam logic [31:0] COOLDOWN_RST = 32'd600000;
   localparam logic [31:0] STALE_RST    = 32'd10000;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;       // capture input item
      logic seen;       // apply station seen
      logic query;      // evaluate query
      logic cool_step;  // tick one cooldown slot
      logic lease_step; // check one lease slot
      logic cool_ins;   // insert pending cooldown
      logic done;       // publish result
   } cmd_type;

   typedef struct packed {
      logic pend;       // a cooldown insert is pending
   } stat_type;
endpackage

>>> hdl/clct_ctrl.sv
// Sequencer for the client lease and cooldown table.
`timescale 1ns / 1ps
module clct_ctrl #(
   parameter int LEASE_SLOTS = clct_pkg::LEASE_SLOTS_DEF,
   parameter int COOL_SLOTS  = clct_pkg::COOL_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [1:0] kind,
   input  logic out_free,
   input  clct_pkg::stat_type stat,
   output logic busy,
   output clct_pkg::cmd_type cmd,
   output logic [$clog2(LEASE_SLOTS+COOL_SLOTS+1)-1:0] idx
);
   localparam int IW = $clog2(LEASE_SLOTS + COOL_SLOTS + 1);
   localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_COOL = 3'd2,
                          S_LEASE = 3'd3, S_INS = 3'd4, S_DONE = 3'd5;
   logic [2:0] state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0] kind_ff, kind_in;

   assign busy = (state_ff != S_IDLE);
   assign idx  = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               kind_in  = kind;
               idx_in   = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (kind_ff == clct_pkg::KIND_SCAN) begin
               state_in = S_COOL;
            end else begin
               cmd.seen  = (kind_ff == clct_pkg::KIND_SEEN);
               cmd.query = (kind_ff == clct_pkg::KIND_QUERY);
               state_in  = S_DONE;
            end
         end
         S_COOL: begin
            cmd.cool_step = 1'b1;
            if (idx_ff == IW'(COOL_SLOTS - 1)) begin
               idx_in   = '0;
               state_in = S_LEASE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LEASE: begin
            cmd.lease_step = 1'b1;
            state_in = S_INS;
         end
         S_INS: begin
            // insert the pending cooldown victim if any, then advance
            cmd.cool_ins = stat.pend;
            if (idx_ff == IW'(LEASE_SLOTS - 1)) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LEASE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         kind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         kind_ff  <= kind_in;
      end
   end
endmodule

>>> hdl/clct_data.sv
// Lease and cooldown tables with their update logic.
`timescale 1ns / 1ps
module clct_data #(
   parameter int LEASE_SLOTS = clct_pkg::LEASE_SLOTS_DEF,
   parameter int COOL_SLOTS  = clct_pkg::COOL_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  clct_pkg::cmd_type cmd,
   input  logic [$clog2(LEASE_SLOTS+COOL_SLOTS+1)-1:0] idx,
   input  logic [47:0] mac,
   input  logic [31:0] now,
   input  logic [31:0] session_ms,
   input  logic [31:0] cooldown_ms,
   input  logic [31:0] stale_ms,
   output clct_pkg::stat_type stat,
   output logic [1:0]  status,
   output logic [31:0] remaining_ms,
   output logic        refused,
   output logic [3:0]  lease_count,
   output logic [3:0]  cooldown_count
);
   localparam int LW = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
   localparam int CW = (COOL_SLOTS > 1) ? $clog2(COOL_SLOTS) : 1;
   localparam int IW = $clog2(LEASE_SLOTS + COOL_SLOTS + 1);

   logic [LEASE_SLOTS-1:0] lv_ff, lexp_ff, lseen_ff;
   logic [47:0] laddr_ff [LEASE_SLOTS];
   logic [31:0] lstart_ff [LEASE_SLOTS];
   logic [31:0] llast_ff [LEASE_SLOTS];
   logic [COOL_SLOTS-1:0] cv_ff, cseen_ff;
   logic [47:0] caddr_ff [COOL_SLOTS];
   logic [31:0] cleft_ff [COOL_SLOTS];
   logic [31:0] ctick_ff [COOL_SLOTS];
   logic [6:0] ltot_ff, ctot_ff;
   logic [47:0] mac_ff;
   logic [31:0] now_ff;
   logic [1:0]  status_ff;
   logic [31:0] rem_ff;
   logic        ref_ff;
   logic        pend_ff;
   logic [47:0] pmac_ff;

   // Lookups: lowest-index match.
   logic l_hit, c_hit, l_free_hit, c_free_hit, p_hit;
   logic [LW-1:0] l_idx, l_free;
   logic [CW-1:0] c_idx, c_free, c_min, p_idx;
   always_comb begin
      l_hit = 1'b0; l_idx = '0; l_free_hit = 1'b0; l_free = '0;
      for (int i = LEASE_SLOTS - 1; i >= 0; i--) begin
         if (lv_ff[i] && laddr_ff[i] == mac_ff) begin
            l_hit = 1'b1; l_idx = LW'(i);
         end
         if (!lv_ff[i]) begin
            l_free_hit = 1'b1; l_free = LW'(i);
         end
      end
      c_hit = 1'b0; c_idx = '0; c_free_hit = 1'b0; c_free = '0;
      p_hit = 1'b0; p_idx = '0;
      for (int i = COOL_SLOTS - 1; i >= 0; i--) begin
         if (cv_ff[i] && caddr_ff[i] == mac_ff) begin
            c_hit = 1'b1; c_idx = CW'(i);
         end
         if (cv_ff[i] && caddr_ff[i] == pmac_ff) begin
            p_hit = 1'b1; p_idx = CW'(i);
         end
         if (!cv_ff[i]) begin
            c_free_hit = 1'b1; c_free = CW'(i);
         end
      end
      // Victim when full: least time left, ties to lowest index.
      c_min = '0;
      for (int i = 1; i < COOL_SLOTS; i++) begin
         if (cleft_ff[i] < cleft_ff[c_min]) c_min = CW'(i);
      end
   end

   logic [LW-1:0] li;
   logic [CW-1:0] ci;
   assign li = idx[LW-1:0];
   assign ci = idx[CW-1:0];

   logic [31:0] q_el, c_el, l_el, lq_el;
   assign q_el  = now_ff - lstart_ff[l_idx];
   assign c_el  = now_ff - ctick_ff[ci];
   assign l_el  = now_ff - llast_ff[li];
   assign lq_el = q_el;

   assign stat.pend = pend_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mac_ff    <= mac;
         now_ff    <= now;
         status_ff <= clct_pkg::ST_UNKNOWN;
         rem_ff    <= '0;
         ref_ff    <= 1'b0;
      end
      if (cmd.seen) begin
         if (l_hit) begin
            llast_ff[l_idx] <= now_ff;
         end else if (!c_hit && ltot_ff < 7'(LEASE_SLOTS) && l_free_hit) begin
            laddr_ff[l_free]  <= mac_ff;
            lstart_ff[l_free] <= now_ff;
            llast_ff[l_free]  <= now_ff;
         end else if (!c_hit) begin
            ref_ff <= 1'b1;
         end
      end
      if (cmd.query) begin
         if (l_hit) begin
            if (lexp_ff[l_idx]) begin
               status_ff <= clct_pkg::ST_BLOCKED;
               rem_ff    <= cooldown_ms;
            end else if (session_ms == '0) begin
               status_ff <= clct_pkg::ST_UNLIMITED;
            end else begin
               status_ff <= clct_pkg::ST_ACTIVE;
               rem_ff    <= (lq_el >= session_ms) ? '0 : session_ms - lq_el;
            end
         end else if (c_hit) begin
            status_ff <= clct_pkg::ST_BLOCKED;
            rem_ff    <= cleft_ff[c_idx];
         end
      end
      if (cmd.cool_step && cv_ff[ci]) begin
         ctick_ff[ci] <= now_ff;
         if (!cseen_ff[ci])
            cleft_ff[ci] <= (c_el >= cleft_ff[ci]) ? '0 : cleft_ff[ci] - c_el;
      end
      if (cmd.lease_step) pmac_ff <= laddr_ff[li];
      if (cmd.cool_ins) begin
         if (p_hit) begin
            caddr_ff[p_idx] <= pmac_ff; cleft_ff[p_idx] <= cooldown_ms;
            ctick_ff[p_idx] <= now_ff;
         end else if (c_free_hit) begin
            caddr_ff[c_free] <= pmac_ff; cleft_ff[c_free] <= cooldown_ms;
            ctick_ff[c_free] <= now_ff;
         end else begin
            caddr_ff[c_min] <= pmac_ff; cleft_ff[c_min] <= cooldown_ms;
            ctick_ff[c_min] <= now_ff;
         end
      end
   end

   // Control bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= '0; lexp_ff <= '0; lseen_ff <= '0;
         cv_ff <= '0; cseen_ff <= '0;
         ltot_ff <= '0; ctot_ff <= '0; pend_ff <= 1'b0;
      end else begin
         if (cmd.seen) begin
            if (c_hit) cseen_ff[c_idx] <= 1'b1;
            if (l_hit) begin
               lseen_ff[l_idx] <= 1'b1;
               if (!lexp_ff[l_idx] && session_ms != '0 && q_el > session_ms)
                  lexp_ff[l_idx] <= 1'b1;
            end else if (!c_hit && ltot_ff < 7'(LEASE_SLOTS) && l_free_hit) begin
               lv_ff[l_free]    <= 1'b1;
               lexp_ff[l_free]  <= 1'b0;
               lseen_ff[l_free] <= 1'b1;
               ltot_ff <= ltot_ff + 1'b1;
            end
         end
         if (cmd.cool_step) begin
            cseen_ff[ci] <= 1'b0;
            if (cv_ff[ci]) begin
               if ((cseen_ff[ci] && cleft_ff[ci] == '0) ||
                   (!cseen_ff[ci] && c_el >= cleft_ff[ci])) begin
                  cv_ff[ci] <= 1'b0;
                  if (ctot_ff != '0) ctot_ff <= ctot_ff - 1'b1;
               end
            end
         end
         // Flag an insert only for an expired lease that leaves.
         pend_ff <= cmd.lease_step && lv_ff[li] && !lseen_ff[li] && (l_el > stale_ms) &&
                    lexp_ff[li] && (cooldown_ms != '0);
         if (cmd.lease_step) begin
            lseen_ff[li] <= 1'b0;
            if (lv_ff[li] && !lseen_ff[li] && l_el > stale_ms) begin
               lv_ff[li]   <= 1'b0;
               lexp_ff[li] <= 1'b0;
               if (ltot_ff != '0) ltot_ff <= ltot_ff - 1'b1;
            end
         end
         if (cmd.cool_ins) begin
            if (p_hit) begin
               cseen_ff[p_idx] <= 1'b0;
            end else if (c_free_hit) begin
               cv_ff[c_free] <= 1'b1; cseen_ff[c_free] <= 1'b0;
               if (ctot_ff < 7'(COOL_SLOTS)) ctot_ff <= ctot_ff + 1'b1;
            end else begin
               cseen_ff[c_min] <= 1'b0;
            end
         end
      end
   end

   assign status         = status_ff;
   assign remaining_ms   = rem_ff;
   assign refused        = ref_ff;
   assign lease_count    = ltot_ff[3:0];
   assign cooldown_count = ctot_ff[3:0];

   logic unused_idx;
   assign unused_idx = ^idx[IW-1:0];
endmodule

>>> hdl/client_lease_cooldown_table_core.sv
// Top level of the client lease and cooldown table.
`timescale 1ns / 1ps
// Channel   Dir  Payload
// req_      in   tuser: kind[1:0]; tdata: mac[47:0], now[79:48]
// rsp_      out  tdata: status[1:0], remaining_ms[33:2], refused[34],
//                       lease_count[38:35], cooldown_count[42:39], pad to 48
// csr_      in   write: index 0 session_ms, 1 cooldown_ms, 2 stale_ms
// A seen, query or unused-kind item goes from accept through the execute state to the done state.
// An end of scan walks the cooldown table one slot per cycle, then the lease
// table slot by slot through a check state and an insert state.
// Reset is synchronous; it empties both tables and restores the registers.
// The sequencer frees req_tready once it loads the result register; a stalled rsp_ holds
// the next item's result in the sequencer's final state.
`include "client_lease_cooldown_table_core_macros.svh"
module client_lease_cooldown_table_core #(
   parameter int LEASE_SLOTS = clct_pkg::LEASE_SLOTS_DEF,
   parameter int COOL_SLOTS  = clct_pkg::COOL_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // mac, now
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status, remaining_ms, refused, lease_count, cooldown_count
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int IW = $clog2(LEASE_SLOTS + COOL_SLOTS + 1);
   logic [31:0] session_ff, cool_ff, stale_ff;
   logic busy, start, out_free;
   logic rsp_valid_ff;
   logic [42:0] rsp_data_ff;
   logic [IW-1:0] idx;
   clct_pkg::cmd_type cmd;
   clct_pkg::stat_type stat;
   logic [1:0] status;
   logic [31:0] remaining_ms;
   logic refused;
   logic [3:0] lease_count, cooldown_count;

   // Hold configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff <= clct_pkg::SESSION_RST;
         cool_ff    <= clct_pkg::COOLDOWN_RST;
         stale_ff   <= clct_pkg::STALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            clct_pkg::REG_SESSION:  session_ff <= csr_wdata;
            clct_pkg::REG_COOLDOWN: cool_ff    <= csr_wdata;
            clct_pkg::REG_STALE:    stale_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !busy;
   assign start      = req_tvalid && !busy;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   clct_ctrl #(.LEASE_SLOTS(LEASE_SLOTS), .COOL_SLOTS(COOL_SLOTS)) u_ctrl (
      .clock, .reset, .start, .kind(req_tuser), .out_free, .stat,
      .busy, .cmd, .idx
   );

   clct_data #(.LEASE_SLOTS(LEASE_SLOTS), .COOL_SLOTS(COOL_SLOTS)) u_data (
      .clock, .reset, .cmd, .idx, .mac(req_tdata[47:0]), .now(req_tdata[79:48]),
      .session_ms(session_ff), .cooldown_ms(cool_ff), .stale_ms(stale_ff),
      .stat, .status, .remaining_ms, .refused, .lease_count, .cooldown_count
   );

   // Advance the result register on done, drop it once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.done)
         rsp_data_ff <= {cooldown_count, lease_count, refused, remaining_ms, status};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   `CLCT_ASSERT_IMP(a_count_range, clock, reset, rsp_tvalid, (rsp_tdata[38:35] <= 4'(LEASE_SLOTS)) && (rsp_tdata[42:39] <= 4'(COOL_SLOTS)))
   `CLCT_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `CLCT_ASSERT_IMP(a_refused_alone, clock, reset, rsp_tvalid && rsp_tdata[34], rsp_tdata[1:0] == clct_pkg::ST_UNKNOWN)
endmodule
